### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the relocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked assertion, disabled while reset is asserted
`define ACR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked assertion, checked in reset as well
`define ACR_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACR_ASSERT(lbl, clk, rstn, prop, msg)
`define ACR_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/acr_pkg.sv
// ----------------------------------------------------------------------------
// acr_pkg
// Types, constants and the opcode match table of the code relocator.
// ----------------------------------------------------------------------------
package acr_pkg;

    localparam int unsigned TableLen    = 16;
    localparam int unsigned AddrWidth   = 64;
    localparam int unsigned CfgIdxWidth = 3;

    // match table entries of interest
    localparam logic [4:0] NO_MATCH    = 5'd16;
    localparam logic [4:0] ENTRY_ADRP  = 5'd3;
    localparam logic [4:0] ENTRY_BL    = 5'd7;
    localparam logic [4:0] ENTRY_B     = 5'd9;
    localparam logic [4:0] ENTRY_BCOND = 5'd10;

    localparam logic [63:0] PAGE_MASK = ~64'hFFF;

    localparam logic [31:0] MATCH_MASK [TableLen] = '{
        32'hFFC00000, 32'hFFC00000, 32'hFFC00000, 32'h9F000000,
        32'h7F000000, 32'hFFF00000, 32'hFFF00000, 32'hFC000000,
        32'hFFFFFC1F, 32'hFC000000, 32'hFF000010, 32'hFFC00000,
        32'hFFF00000, 32'hFF800000, 32'hFF00001F, 32'hFFE00000
    };
    localparam logic [31:0] MATCH_VALUE [TableLen] = '{
        32'hA9800000, 32'h52800000, 32'hD2800000, 32'h90000000,
        32'h11000000, 32'hF9400000, 32'hF9000000, 32'h94000000,
        32'hEB00001F, 32'h14000000, 32'h54000000, 32'hB9000000,
        32'hB9400000, 32'h72800000, 32'h6B00001F, 32'hAA000000
    };

    // configuration register indexes
    typedef enum logic [CfgIdxWidth-1:0] {
        REG_SRC_CODE_BASE  = 3'd0,
        REG_DST_CODE_BASE  = 3'd1,
        REG_CODE_BYTES     = 3'd2,
        REG_SRC_DATA_START = 3'd3,
        REG_DST_DATA_START = 3'd4,
        REG_DATA_BYTES     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [63:0] src_code_base;
        logic [63:0] dst_code_base;
        logic [31:0] code_bytes;
        logic [63:0] src_data_start;
        logic [63:0] dst_data_start;
        logic [31:0] data_bytes;
    } cfg_t;

    // stage 1: decoded word with source and destination pc
    typedef struct packed {
        logic [31:0] word;
        logic [4:0]  hit;
        logic [63:0] pc;
        logic [63:0] dpc;
    } s1_t;

    // stage 2: branch or page target
    typedef struct packed {
        logic [31:0] word;
        logic [4:0]  hit;
        logic [63:0] target;
        logic [63:0] dpc;
    } s2_t;

    // stage 3: region offset, branch distance, data move offset
    typedef struct packed {
        logic [31:0] word;
        logic [4:0]  hit;
        logic [63:0] off;
        logic [63:0] diff;
        logic [63:0] kofs;
    } s3_t;

    // first matching table entry, NO_MATCH if none
    function automatic logic [4:0] match_entry(input logic [31:0] w);
        logic [4:0] hit;
        hit = NO_MATCH;
        for (int i = TableLen - 1; i >= 0; i--) begin
            if ((w & MATCH_MASK[i]) == MATCH_VALUE[i]) begin
                hit = 5'(i);
            end
        end
        return hit;
    endfunction

endpackage

### rtl/core/acr_in_if.sv
// ----------------------------------------------------------------------------
// acr_in_if
// Input channel: instruction word and its index in the code image.
// ----------------------------------------------------------------------------
interface acr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;
    logic [29:0] word_index;

    modport source (output valid, output instr_word, output word_index, input ready);
    modport sink   (input valid, input instr_word, input word_index, output ready);
endinterface

### rtl/core/acr_out_if.sv
// ----------------------------------------------------------------------------
// acr_out_if
// Output channel: relocated word, table hit and branch range flag.
// ----------------------------------------------------------------------------
interface acr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] new_word;
    logic [4:0]  match_index;
    logic        branch_out_of_range;

    modport source (output valid, output new_word, output match_index,
                    output branch_out_of_range, input ready);
    modport sink   (input valid, input new_word, input match_index,
                    input branch_out_of_range, output ready);
endinterface

### rtl/core/acr_cfg.sv
// ----------------------------------------------------------------------------
// acr_cfg
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
module acr_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [acr_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [acr_pkg::AddrWidth-1:0]       cfg_wdata,
    output acr_pkg::cfg_t                       cfg
);
    import acr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the write; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SRC_CODE_BASE:  cfg_next.src_code_base  = cfg_wdata;
                REG_DST_CODE_BASE:  cfg_next.dst_code_base  = cfg_wdata;
                REG_CODE_BYTES:     cfg_next.code_bytes     = cfg_wdata[31:0];
                REG_SRC_DATA_START: cfg_next.src_data_start = cfg_wdata;
                REG_DST_DATA_START: cfg_next.dst_data_start = cfg_wdata;
                REG_DATA_BYTES:     cfg_next.data_bytes     = cfg_wdata[31:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/acr_front.sv
// ----------------------------------------------------------------------------
// acr_front
// Stages 1 and 2: opcode match and pc sums, then target address.
// ----------------------------------------------------------------------------
module acr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [31:0]   instr_word,
    input  logic [29:0]   word_index,
    input  acr_pkg::cfg_t cfg,
    output logic          s2_valid,
    output acr_pkg::s2_t  s2
);
    import acr_pkg::*;

    logic s1_valid_reg;
    s1_t  s1_reg;
    s1_t  s1_next;
    logic s2_valid_reg;
    s2_t  s2_reg;
    s2_t  s2_next;

    logic [63:0] byte_off;
    logic [63:0] base;
    logic [63:0] disp;

    // match the word, form source and destination pc
    always_comb
    begin
        byte_off     = {32'd0, word_index, 2'b00};
        s1_next.word = instr_word;
        s1_next.hit  = match_entry(instr_word);
        s1_next.pc   = cfg.src_code_base + byte_off;
        s1_next.dpc  = cfg.dst_code_base + byte_off;
    end

    // add the scaled immediate of the matched form
    always_comb
    begin
        base = s1_reg.pc;
        disp = '0;
        priority if (s1_reg.hit == ENTRY_B || s1_reg.hit == ENTRY_BL)
        begin
            disp = {{36{s1_reg.word[25]}}, s1_reg.word[25:0], 2'b00};
        end
        else if (s1_reg.hit == ENTRY_BCOND)
        begin
            disp = {{43{s1_reg.word[23]}}, s1_reg.word[23:5], 2'b00};
        end
        else if (s1_reg.hit == ENTRY_ADRP)
        begin
            base = s1_reg.pc & PAGE_MASK;
            disp = {{31{s1_reg.word[23]}}, s1_reg.word[23:5], s1_reg.word[30:29], 12'd0};
        end
        else
        begin
            disp = '0;
        end
        s2_next.word   = s1_reg.word;
        s2_next.hit    = s1_reg.hit;
        s2_next.target = base + disp;
        s2_next.dpc    = s1_reg.dpc;
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // advance payload, hold on stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;

`include "assert_macros.svh"

    `ACR_ASSERT(a_s1_hold, clk, rst_n, !en |=> $stable(s1_valid_reg), "stage 1 valid moved in a stall")

endmodule

### rtl/core/acr_back.sv
// ----------------------------------------------------------------------------
// acr_back
// Stages 3 and 4: region offsets and distances, then word re-encoding.
// ----------------------------------------------------------------------------
module acr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          s2_valid,
    input  acr_pkg::s2_t  s2,
    input  acr_pkg::cfg_t cfg,
    output logic          out_valid,
    output logic [31:0]   new_word,
    output logic [4:0]    match_index,
    output logic          branch_out_of_range
);
    import acr_pkg::*;

    logic        s3_valid_reg;
    s3_t         s3_reg;
    s3_t         s3_next;
    logic        out_valid_reg;
    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic [4:0]  match_reg;
    logic        flag_reg;
    logic        flag_next;

    logic        is_adrp;
    logic [31:0] bytes;
    logic        in_range;
    logic        fits;
    logic [63:0] rel;

    // offset into the region, distance to the destination pc
    always_comb
    begin
        is_adrp      = (s2.hit == ENTRY_ADRP);
        s3_next.word = s2.word;
        s3_next.hit  = s2.hit;
        s3_next.off  = s2.target - (is_adrp ? cfg.src_data_start : cfg.src_code_base);
        s3_next.diff = s2.target - s2.dpc;
        s3_next.kofs = cfg.dst_data_start - (s2.dpc & PAGE_MASK);
    end

    // region test and re-encoding
    always_comb
    begin
        bytes     = (s3_reg.hit == ENTRY_ADRP) ? cfg.data_bytes : cfg.code_bytes;
        in_range  = (s3_reg.off[63:32] == 32'd0) && (s3_reg.off[31:0] < bytes);
        fits      = (&s3_reg.diff[63:27]) || !(|s3_reg.diff[63:27]);
        rel       = s3_reg.kofs + s3_reg.off;
        word_next = s3_reg.word;
        flag_next = 1'b0;
        priority if (s3_reg.hit == ENTRY_B || s3_reg.hit == ENTRY_BL)
        begin
            if (!in_range)
            begin
                word_next = {s3_reg.word[31:26], s3_reg.diff[27:2]};
                flag_next = !fits;
            end
        end
        else if (s3_reg.hit == ENTRY_BCOND)
        begin
            if (!in_range)
            begin
                word_next = {s3_reg.word[31:24], s3_reg.diff[20:2], s3_reg.word[4:0]};
            end
        end
        else if (s3_reg.hit == ENTRY_ADRP)
        begin
            if (in_range)
            begin
                word_next = {s3_reg.word[31], rel[13:12], s3_reg.word[28:24],
                             rel[32:14], s3_reg.word[4:0]};
            end
        end
        else
        begin
            word_next = s3_reg.word;
        end
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg  <= s2_valid;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // advance payload, hold on stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg    <= s3_next;
            word_reg  <= word_next;
            match_reg <= s3_reg.hit;
            flag_reg  <= flag_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign new_word            = word_reg;
    assign match_index         = match_reg;
    assign branch_out_of_range = flag_reg;

`include "assert_macros.svh"

    `ACR_ASSERT(a_flag_branch, clk, rst_n, out_valid_reg && flag_reg |-> (match_reg == ENTRY_B || match_reg == ENTRY_BL), "range flag on a word that is not b or bl")
    `ACR_ASSERT(a_pass_through, clk, rst_n, en && s3_valid_reg && s3_reg.hit == NO_MATCH |=> word_reg == $past(s3_reg.word), "unmatched word was altered")
    `ACR_ASSERT(a_b_opcode, clk, rst_n, out_valid_reg && match_reg == ENTRY_B |-> word_reg[31:26] == 6'b000101, "b opcode bits lost")
    `ACR_ASSERT_NR(a_match_range, clk, out_valid_reg |-> match_reg <= NO_MATCH, "match index beyond table")

endmodule

### rtl/core/aarch64_code_relocator.sv
// ----------------------------------------------------------------------------
// aarch64_code_relocator
// Rewrites pc-relative b, bl, b.cond and adrp words of a moved code image.
//
//   channel   dir   payload                                      handshake
//   in_ch     in    instr_word[31:0], word_index[29:0]           valid/ready
//   out_ch    out   new_word[31:0], match_index[4:0], flag[0]    valid/ready
//   cfg       in    cfg_index[2:0], cfg_wdata[63:0]              cfg_we
//
// One item per cycle while the output is not stalled, through the four-stage
// pipeline (match and pc sums, target add, offsets, re-encode).
// Reset clears the pipeline valid bits and all configuration registers.
// A result held at the output freezes the whole pipeline; in_ch.ready
// is low exactly while out_ch.valid is high and out_ch.ready is low.
// ----------------------------------------------------------------------------
module aarch64_code_relocator (
    input  logic                            clk,
    input  logic                            rst_n,
    acr_in_if.sink                          in_ch,
    acr_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [acr_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [acr_pkg::AddrWidth-1:0]   cfg_wdata
);
    import acr_pkg::*;

    cfg_t cfg;
    logic en;
    logic s2_valid;
    s2_t  s2;
    logic out_valid;

    // advance the pipeline unless the output item is stalled
    assign en          = !out_valid || out_ch.ready;
    assign in_ch.ready = en;
    assign out_ch.valid = out_valid;

    acr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    acr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_ch.valid),
        .instr_word (in_ch.instr_word),
        .word_index (in_ch.word_index),
        .cfg        (cfg),
        .s2_valid   (s2_valid),
        .s2         (s2)
    );

    acr_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .en                  (en),
        .s2_valid            (s2_valid),
        .s2                  (s2),
        .cfg                 (cfg),
        .out_valid           (out_valid),
        .new_word            (out_ch.new_word),
        .match_index         (out_ch.match_index),
        .branch_out_of_range (out_ch.branch_out_of_range)
    );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for aarch64_code_relocator. A short table of directed
// words runs first, then random words under several register settings. Each
// accepted unpinned word is relocated by a predictor in this file, a pinned
// row gets its own want; new word, table hit and range flag are then compared.
// ----------------------------------------------------------------------------
module testbench;
    import acr_pkg::*;

    localparam int PIPE_LATENCY   = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_ITEMS    = 100;
    localparam int NUM_PHASES     = 7;
    localparam int NUM_ROWS       = 24;

    localparam logic [63:0] PAGE_LOW = 64'hFFF;

    // indexes beyond the last register, expected to be ignored
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    // opcode table entries, in first-match order
    typedef enum logic [4:0] {
        OP_STP_PRE = 5'd0,
        OP_MOVZ_W  = 5'd1,
        OP_MOVZ_X  = 5'd2,
        OP_ADRP    = ENTRY_ADRP,
        OP_ADD_IMM = 5'd4,
        OP_LDR_X   = 5'd5,
        OP_STR_X   = 5'd6,
        OP_BL      = ENTRY_BL,
        OP_CMP_X   = 5'd8,
        OP_B       = ENTRY_B,
        OP_BCOND   = ENTRY_BCOND,
        OP_STR_W   = 5'd11,
        OP_LDR_W   = 5'd12,
        OP_MOVK_W  = 5'd13,
        OP_CMP_W   = 5'd14,
        OP_ORR_X   = 5'd15,
        OP_NONE    = NO_MATCH
    } opc_t;

    localparam logic [31:0] OPC_MASK [16] = '{
        32'hFFC00000, 32'hFFC00000, 32'hFFC00000, 32'h9F000000,
        32'h7F000000, 32'hFFF00000, 32'hFFF00000, 32'hFC000000,
        32'hFFFFFC1F, 32'hFC000000, 32'hFF000010, 32'hFFC00000,
        32'hFFF00000, 32'hFF800000, 32'hFF00001F, 32'hFFE00000
    };
    localparam logic [31:0] OPC_VALUE [16] = '{
        32'hA9800000, 32'h52800000, 32'hD2800000, 32'h90000000,
        32'h11000000, 32'hF9400000, 32'hF9000000, 32'h94000000,
        32'hEB00001F, 32'h14000000, 32'h54000000, 32'hB9000000,
        32'hB9400000, 32'h72800000, 32'h6B00001F, 32'hAA000000
    };

    typedef enum int {
        SET_ZERO,
        SET_ONES,
        SET_NEAR,
        SET_FAR,
        SET_WRAP,
        SET_EMPTY,
        SET_RANDOM
    } setting_t;

    localparam setting_t PHASE_ORDER [NUM_PHASES] = '{
        SET_NEAR, SET_FAR, SET_ZERO, SET_WRAP, SET_ONES, SET_EMPTY, SET_RANDOM
    };

    typedef struct packed {
        logic [31:0] word;
        opc_t        hit;
        logic        flag;
    } reloc_t;

    typedef struct packed {
        logic [31:0] word;
        logic [29:0] index;
        logic        at_reset;
        logic        pinned;
        reloc_t      want;
    } dir_row_t;

    // settings used by the rows that are not run at reset
    localparam logic [63:0] TYP_SRC_CODE  = 64'h0000_0000_4008_0000;
    localparam logic [63:0] TYP_DST_CODE  = 64'hFFFF_0000_1234_0000;
    localparam logic [31:0] TYP_CODE_SIZE = 32'h0001_0000;
    localparam logic [63:0] TYP_SRC_DATA  = 64'h0000_0000_4010_0000;
    localparam logic [63:0] TYP_DST_DATA  = 64'hFFFF_0000_2000_0000;
    localparam logic [31:0] TYP_DATA_SIZE = 32'h0002_0000;

    // rows at reset have every region empty and both bases equal: words pass as is
    localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{32'h00000000, 30'h0,        1'b1, 1'b1, '{32'h00000000, OP_NONE,    1'b0}},
        '{32'hFFFFFFFF, 30'h3FFFFFFF, 1'b1, 1'b1, '{32'hFFFFFFFF, OP_NONE,    1'b0}},
        '{32'h17FFFFFF, 30'h0,        1'b1, 1'b1, '{32'h17FFFFFF, OP_B,       1'b0}},
        '{32'h97FFFFFF, 30'h3FFFFFFF, 1'b1, 1'b1, '{32'h97FFFFFF, OP_BL,      1'b0}},
        '{32'h54FFFFEF, 30'h5,        1'b1, 1'b1, '{32'h54FFFFEF, OP_BCOND,   1'b0}},
        '{32'hF0FFFFFF, 30'h3FFFFFFF, 1'b1, 1'b1, '{32'hF0FFFFFF, OP_ADRP,    1'b0}},
        '{32'hA9800000, 30'h1,        1'b1, 1'b1, '{32'hA9800000, OP_STP_PRE, 1'b0}},
        '{32'h52800000, 30'h2,        1'b1, 1'b1, '{32'h52800000, OP_MOVZ_W,  1'b0}},
        '{32'hD2800000, 30'h3,        1'b1, 1'b1, '{32'hD2800000, OP_MOVZ_X,  1'b0}},
        '{32'h11000000, 30'h4,        1'b1, 1'b1, '{32'h11000000, OP_ADD_IMM, 1'b0}},
        '{32'hF9400000, 30'h6,        1'b1, 1'b1, '{32'hF9400000, OP_LDR_X,   1'b0}},
        '{32'hF9000000, 30'h7,        1'b1, 1'b1, '{32'hF9000000, OP_STR_X,   1'b0}},
        '{32'hEB00001F, 30'h8,        1'b1, 1'b1, '{32'hEB00001F, OP_CMP_X,   1'b0}},
        '{32'hB9000000, 30'h9,        1'b1, 1'b1, '{32'hB9000000, OP_STR_W,   1'b0}},
        '{32'hB9400000, 30'hA,        1'b1, 1'b1, '{32'hB9400000, OP_LDR_W,   1'b0}},
        '{32'h72800000, 30'hB,        1'b1, 1'b1, '{32'h72800000, OP_MOVK_W,  1'b0}},
        '{32'h6B00001F, 30'hC,        1'b1, 1'b1, '{32'h6B00001F, OP_CMP_W,   1'b0}},
        '{32'hAA000000, 30'hD,        1'b1, 1'b1, '{32'hAA000000, OP_ORR_X,   1'b0}},
        '{32'h14000010, 30'h4,        1'b0, 1'b0, '{32'h0,        OP_NONE,    1'b0}},
        '{32'h14200000, 30'h0,        1'b0, 1'b0, '{32'h0,        OP_NONE,    1'b0}},
        '{32'h97000000, 30'hA,        1'b0, 1'b0, '{32'h0,        OP_NONE,    1'b0}},
        '{32'h54100001, 30'h2,        1'b0, 1'b0, '{32'h0,        OP_NONE,    1'b0}},
        '{32'h90000405, 30'h7,        1'b0, 1'b0, '{32'h0,        OP_NONE,    1'b0}},
        '{32'h90000005, 30'h0,        1'b0, 1'b0, '{32'h0,        OP_NONE,    1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [AddrWidth-1:0]   cfg_wdata;

    acr_in_if  in_ch ();
    acr_out_if out_ch ();

    aarch64_code_relocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // shadow copy of the relocation registers
    logic [63:0] cur_src_code;
    logic [63:0] cur_dst_code;
    logic [31:0] cur_code_bytes;
    logic [63:0] cur_src_data;
    logic [63:0] cur_dst_data;
    logic [31:0] cur_data_bytes;

    reloc_t pending_relocs [$];
    int     mismatch_count = 0;
    bit     pin_active     = 1'b0;
    reloc_t pin_want       = '0;
    bit     hold_request   = 1'b0;
    int     in_quiet_left  = 0;
    int     rx_quiet_left  = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit in_window(input logic [63:0] a, input logic [63:0] base,
                                     input logic [31:0] bytes);
        return (a - base) < {32'd0, bytes};
    endfunction

    // Relocate one word under the current register settings
    function automatic reloc_t relocate_word(input logic [31:0] w, input logic [29:0] idx);
        reloc_t      r;
        logic [63:0] byte_off;
        logic [63:0] pc;
        logic [63:0] dpc;
        logic [63:0] target;
        logic [63:0] diff;
        logic [63:0] moved;
        logic [63:0] rel;
        bit          found;
        byte_off = {32'd0, idx, 2'b00};
        pc       = cur_src_code + byte_off;
        dpc      = cur_dst_code + byte_off;
        r.word   = w;
        r.hit    = OP_NONE;
        r.flag   = 1'b0;
        found    = 1'b0;
        for (int i = 0; i < 16; i++)
        begin
            if (!found && (w & OPC_MASK[i]) == OPC_VALUE[i])
            begin
                r.hit = opc_t'(i);
                found = 1'b1;
            end
        end
        case (r.hit)
            OP_B, OP_BL:
            begin
                target = pc + {{36{w[25]}}, w[25:0], 2'b00};
                if (!in_window(target, cur_src_code, cur_code_bytes))
                begin
                    diff   = target - dpc;
                    r.flag = (diff + 64'h0000_0000_0800_0000) >= 64'h0000_0000_1000_0000;
                    r.word = {w[31:26], diff[27:2]};
                end
            end
            OP_BCOND:
            begin
                target = pc + {{43{w[23]}}, w[23:5], 2'b00};
                if (!in_window(target, cur_src_code, cur_code_bytes))
                begin
                    diff   = target - dpc;
                    r.word = {w[31:24], diff[20:2], w[4:0]};
                end
            end
            OP_ADRP:
            begin
                target = (pc & ~PAGE_LOW) + {{31{w[23]}}, w[23:5], w[30:29], 12'd0};
                if (in_window(target, cur_src_data, cur_data_bytes))
                begin
                    moved  = cur_dst_data + (target - cur_src_data);
                    rel    = moved - (dpc & ~PAGE_LOW);
                    r.word = {w[31], rel[13:12], w[28:24], rel[32:14], w[4:0]};
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Compare each result with the oldest expectation, queue one per accepted item
    always @(posedge clk)
    begin : score
        reloc_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_relocs.size() == 0)
                begin
                    $error("result with no item outstanding: new_word %h", out_ch.new_word);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_relocs.pop_front();
                    if (out_ch.new_word !== want.word)
                    begin
                        $error("new_word: expected %h, actual %h", want.word, out_ch.new_word);
                        mismatch_count++;
                    end
                    if (out_ch.match_index !== want.hit)
                    begin
                        $error("match_index: expected %0d, actual %0d", want.hit,
                               out_ch.match_index);
                        mismatch_count++;
                    end
                    if (out_ch.branch_out_of_range !== want.flag)
                    begin
                        $error("branch_out_of_range: expected %0b, actual %0b", want.flag,
                               out_ch.branch_out_of_range);
                        mismatch_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                pending_relocs.push_back(pin_active ? pin_want :
                                         relocate_word(in_ch.instr_word, in_ch.word_index));
            end
        end
    end

    // Write one register at a falling edge and track it in the shadow copy
    task automatic write_reg(input logic [2:0] which, input logic [63:0] val);
        cfg_we    = 1'b1;
        cfg_index = which;
        cfg_wdata = val;
        case (which)
            REG_SRC_CODE_BASE:  cur_src_code   = val;
            REG_DST_CODE_BASE:  cur_dst_code   = val;
            REG_CODE_BYTES:     cur_code_bytes = val[31:0];
            REG_SRC_DATA_START: cur_src_data   = val;
            REG_DST_DATA_START: cur_dst_data   = val;
            REG_DATA_BYTES:     cur_data_bytes = val[31:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
    endtask

    task automatic load_regs(input logic [63:0] sc, input logic [63:0] dc,
                             input logic [31:0] cb, input logic [63:0] sd,
                             input logic [63:0] dd, input logic [31:0] db);
        write_reg(REG_SRC_CODE_BASE, sc);
        write_reg(REG_DST_CODE_BASE, dc);
        write_reg(REG_CODE_BYTES, {$urandom, cb});
        write_reg(REG_SRC_DATA_START, sd);
        write_reg(REG_DST_DATA_START, dd);
        write_reg(REG_DATA_BYTES, {$urandom, db});
        // stray writes last, so a decode slip would clobber a live register
        write_reg(REG_SPARE_6, rand64());
        write_reg(REG_SPARE_7, rand64());
        cfg_we = 1'b0;
    endtask

    task automatic load_setting(input setting_t kind);
        logic [63:0] sc;
        logic [63:0] dc;
        logic [63:0] sd;
        logic [63:0] dd;
        logic [31:0] cb;
        logic [31:0] db;
        sc = rand64();
        dc = rand64();
        sd = rand64();
        dd = rand64();
        cb = $urandom_range(16, 32'h0010_0000);
        db = $urandom_range(32'h1000, 32'h0010_0000);
        case (kind)
            SET_ZERO:
            begin
                sc = '0; dc = '0; sd = '0; dd = '0; cb = '0; db = '0;
            end
            SET_ONES:
            begin
                sc = '1; dc = '1; sd = '1; dd = '1; cb = '1; db = '1;
            end
            SET_NEAR:
            begin
                sc = sc & ~PAGE_LOW;
                dc = sc + {{40{dc[23]}}, dc[23:0]};
                sd = sc + {32'd0, cb} + {32'd0, $urandom_range(0, 32'h0010_0000)};
                dd = dc + (sd - sc);
            end
            SET_WRAP:
            begin
                sc = 64'hFFFF_FFFF_FFFF_0000 + {32'd0, $urandom_range(0, 32'hF000)};
                cb = 32'h0002_0000;
                dc = {32'd0, $urandom_range(0, 32'hFFFF)};
                sd = 64'hFFFF_FFFF_FFF0_0000;
                db = 32'h0020_0000;
                dd = 64'h0000_0000_1000_0000;
            end
            SET_EMPTY:
            begin
                cb = '0;
                db = '0;
            end
            SET_RANDOM:
            begin
                cb = $urandom;
                db = $urandom;
            end
            default:
            begin
            end
        endcase
        load_regs(sc, dc, cb, sd, dd, db);
    endtask

    // Small signed offset, so branch targets land near the code window edges
    function automatic logic [25:0] near_offset();
        int span;
        int v;
        span = 1 << $urandom_range(2, 20);
        v    = int'($urandom_range(0, 2 * span)) - span;
        return v[25:0];
    endfunction

    // Build one random word: mostly branches and adrp aimed at the regions
    task automatic pick_word(output logic [31:0] w, output logic [29:0] idx);
        logic [63:0] pc_page;
        logic [63:0] page;
        logic [63:0] delta;
        logic [63:0] ofs;
        logic [25:0] br_ofs;
        logic [20:0] imm21;
        logic [31:0] rnd;
        int          kind;
        int          ent;
        rnd  = $urandom;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0)
            idx = 30'($urandom);
        else
            idx = 30'($urandom_range(0, (cur_code_bytes >> 2) + 16));
        br_ofs = ($urandom_range(0, 1) == 0) ? 26'($urandom) : near_offset();
        if (kind < 20)
            w = {6'b000101, br_ofs};
        else if (kind < 35)
            w = {6'b100101, br_ofs};
        else if (kind < 50)
            w = {8'h54, br_ofs[18:0], 1'b0, rnd[3:0]};
        else if (kind < 75)
        begin
            imm21 = 21'($urandom);
            if (cur_data_bytes != 0 && $urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       ofs = {32'd0, cur_data_bytes} - 64'd1;
                    1:       ofs = {32'd0, cur_data_bytes};
                    default: ofs = {32'd0, $urandom % cur_data_bytes};
                endcase
                page    = cur_src_data + ofs;
                pc_page = (cur_src_code + {32'd0, idx, 2'b00}) & ~PAGE_LOW;
                delta   = page - pc_page;
                imm21   = delta[32:12];
            end
            w = {1'b1, imm21[1:0], 5'b10000, imm21[20:2], rnd[4:0]};
        end
        else if (kind < 88)
        begin
            ent = $urandom_range(0, 15);
            w   = OPC_VALUE[ent] | (rnd & ~OPC_MASK[ent]);
        end
        else
            w = rnd;
    endtask

    // Offer one item after a random gap and hold it until accepted
    task automatic drive_word(input logic [31:0] w, input logic [29:0] idx,
                              input bit pinned, input reloc_t want);
        int gap;
        if (in_quiet_left > 0)
        begin
            in_quiet_left--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 18);
            if ($urandom_range(0, 29) == 0)
                in_quiet_left = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.instr_word = w;
        in_ch.word_index = idx;
        pin_active       = pinned;
        pin_want         = want;
        in_ch.valid      = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every item has come out
    task automatic settle_pipeline();
        in_ch.valid = 1'b0;
        while (pending_relocs.size() != 0) @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    // Receiver: random stalls, quiet stretches, one long hold-off on request
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (rx_quiet_left > 0)
            begin
                rx_quiet_left--;
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 18);
                if ($urandom_range(0, 29) == 0)
                    rx_quiet_left = $urandom_range(10, 40);
            end
            if (stall > 0)
            begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            @(negedge clk);
        end
    end

    // Watchdog: end the run when no item moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Main stimulus
    initial
    begin
        logic [31:0] w;
        logic [29:0] idx;
        bit          typical_loaded;
        typical_loaded   = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.instr_word = '0;
        in_ch.word_index = '0;
        cur_src_code     = '0;
        cur_dst_code     = '0;
        cur_code_bytes   = '0;
        cur_src_data     = '0;
        cur_dst_data     = '0;
        cur_data_bytes   = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows, reset settings first
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (!DIRECTED_ROWS[r].at_reset && !typical_loaded)
            begin
                settle_pipeline();
                load_regs(TYP_SRC_CODE, TYP_DST_CODE, TYP_CODE_SIZE,
                          TYP_SRC_DATA, TYP_DST_DATA, TYP_DATA_SIZE);
                typical_loaded = 1'b1;
            end
            drive_word(DIRECTED_ROWS[r].word, DIRECTED_ROWS[r].index,
                       DIRECTED_ROWS[r].pinned, DIRECTED_ROWS[r].want);
        end
        pin_active = 1'b0;

        // random phases, one register setting each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle_pipeline();
            load_setting(PHASE_ORDER[p]);
            if (p == 1)
            begin
                // back-to-back items against a long receiver hold-off
                hold_request  = 1'b1;
                in_quiet_left = 60;
            end
            repeat (PHASE_ITEMS)
            begin
                pick_word(w, idx);
                drive_word(w, idx, 1'b0, '0);
            end
        end

        settle_pipeline();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
